@@ rtl/rti_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg: shared constants and types for the ray/triangle intersector
// Coordinate width default, distance format and the flag word that travels
// with each item down the pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int DIST_W         = 32;  // Q16.16 distance and max distance
  localparam int FRAC_W         = 16;  // fractional bits of the distance

  typedef struct packed {
    logic valid;
    logic hit;
  } rti_flag_t;

endpackage
`default_nettype wire

@@ rtl/ray_triangle_intersect.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect: two-sided ray/triangle hit test with distance
// Exact integer determinant, barycentric and distance tests followed by a
// pipelined divider for the hit distance in Q16.16.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Word
// --------+----------------------+---------------------------------------------
// in      | in_valid_i/in_ready_o | ray_origin, ray_direction, max_distance,
//         |                      | vertex_a, vertex_b, vertex_c
// out     | out_valid_o/out_ready_i | hit, distance
//
// One word per cycle in and out unless the pipe holds. The pipe has 4
// geometry stages, 3 test stages and 32 divider stages, one quotient bit
// each; the last divider stage is the output register.
// Reset clears only the valid and hit flags; the pipe is empty after reset.
// The whole pipe holds while a result waits and out_ready_i is low;
// in_ready_o is low only then.
// ----------------------------------------------------------------------------
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [3*COORD_BITS-1:0]  ray_origin_i,
  input  logic [3*COORD_BITS-1:0]  ray_direction_i,
  input  logic [DIST_W-1:0]        max_distance_i,
  input  logic [3*COORD_BITS-1:0]  vertex_a_i,
  input  logic [3*COORD_BITS-1:0]  vertex_b_i,
  input  logic [3*COORD_BITS-1:0]  vertex_c_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     hit_o,
  output logic [DIST_W-1:0]        distance_o
);

  localparam int DW = 3 * COORD_BITS + 6;
  localparam int NW = 3 * COORD_BITS + 7;

  logic                 adv;
  logic                 g_valid;
  logic signed [DW-1:0] det, un, vn, tn;
  logic [DIST_W-1:0]    g_maxd;
  rti_flag_t            t_flag, d_flag;
  logic [NW-1:0]        t_det, t_tn;
  logic [DIST_W-1:0]    quot;

  // advance every stage unless a finished word is held at the output
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  rti_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_valid_i),
    .origin_i (ray_origin_i),
    .dir_i    (ray_direction_i),
    .va_i     (vertex_a_i),
    .vb_i     (vertex_b_i),
    .vc_i     (vertex_c_i),
    .maxd_i   (max_distance_i),
    .valid_o  (g_valid),
    .det_o    (det),
    .un_o     (un),
    .vn_o     (vn),
    .tn_o     (tn),
    .maxd_o   (g_maxd)
  );

  rti_test #(.COORD_BITS(COORD_BITS)) u_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (g_valid),
    .det_i   (det),
    .un_i    (un),
    .vn_i    (vn),
    .tn_i    (tn),
    .maxd_i  (g_maxd),
    .flag_o  (t_flag),
    .det_o   (t_det),
    .tn_o    (t_tn)
  );

  rti_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .flag_i (t_flag),
    .det_i  (t_det),
    .tn_i   (t_tn),
    .flag_o (d_flag),
    .quot_o (quot)
  );

  assign out_valid_o = d_flag.valid;
  assign hit_o       = d_flag.hit;
  assign distance_o  = d_flag.hit ? quot : '0;

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> distance_o == '0)
    else $error("miss with nonzero distance");

  a_fill_on_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("output became valid while the pipe was held");

endmodule
`default_nettype wire

@@ rtl/rti_geom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rti_geom: edges, cross products and the four dot products
// Four register stages: unpack and subtract, cross products, dot-product
// terms, dot-product sums. All stages advance together on adv_i.
// ----------------------------------------------------------------------------
module rti_geom
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic [3*COORD_BITS-1:0]             origin_i,
  input  logic [3*COORD_BITS-1:0]             dir_i,
  input  logic [3*COORD_BITS-1:0]             va_i,
  input  logic [3*COORD_BITS-1:0]             vb_i,
  input  logic [3*COORD_BITS-1:0]             vc_i,
  input  logic [DIST_W-1:0]                   maxd_i,
  output logic                                valid_o,
  output logic signed [3*COORD_BITS+5:0]      det_o,
  output logic signed [3*COORD_BITS+5:0]      un_o,
  output logic signed [3*COORD_BITS+5:0]      vn_o,
  output logic signed [3*COORD_BITS+5:0]      tn_o,
  output logic [DIST_W-1:0]                   maxd_o
);

  localparam int C  = COORD_BITS;
  localparam int MW = 2 * C + 2;   // cross-product term
  localparam int XW = 2 * C + 3;   // cross-product result
  localparam int PW = 3 * C + 4;   // dot-product term
  localparam int DW = 3 * C + 6;   // dot-product sum

  logic [3:0] vld_q;

  logic signed [C-1:0]  d1_q  [3];
  logic signed [C:0]    e1a_q [3];
  logic signed [C:0]    e2a_q [3];
  logic signed [C:0]    ra_q  [3];

  logic signed [C-1:0]  d2_q  [3];
  logic signed [C:0]    e1b_q [3];
  logic signed [C:0]    e2b_q [3];
  logic signed [C:0]    rb_q  [3];
  logic signed [XW-1:0] p_q   [3];
  logic signed [XW-1:0] q_q   [3];

  logic signed [PW-1:0] det_t_q [3];
  logic signed [PW-1:0] un_t_q  [3];
  logic signed [PW-1:0] vn_t_q  [3];
  logic signed [PW-1:0] tn_t_q  [3];

  logic [DIST_W-1:0] md1_q, md2_q, md3_q, md4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  genvar k;
  for (k = 0; k < 3; k++) begin : g_axis
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    logic signed [C-1:0]  o_s, d_s, a_s, b_s, c_s;
    logic signed [MW-1:0] pm1, pm2, qm1, qm2;
    logic signed [PW-1:0] det_m, un_m, vn_m, tn_m;

    assign o_s = $signed(origin_i[k*C +: C]);
    assign d_s = $signed(dir_i[k*C +: C]);
    assign a_s = $signed(va_i[k*C +: C]);
    assign b_s = $signed(vb_i[k*C +: C]);
    assign c_s = $signed(vc_i[k*C +: C]);

    // p = d x e2, q = r x e1
    assign pm1 = d1_q[K1] * e2a_q[K2];
    assign pm2 = d1_q[K2] * e2a_q[K1];
    assign qm1 = ra_q[K1] * e1a_q[K2];
    assign qm2 = ra_q[K2] * e1a_q[K1];

    assign det_m = e1b_q[k] * p_q[k];
    assign un_m  = rb_q[k] * p_q[k];
    assign vn_m  = d2_q[k] * q_q[k];
    assign tn_m  = e2b_q[k] * q_q[k];

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        d1_q[k]  <= d_s;
        e1a_q[k] <= (C+1)'(b_s) - (C+1)'(a_s);
        e2a_q[k] <= (C+1)'(c_s) - (C+1)'(a_s);
        ra_q[k]  <= (C+1)'(o_s) - (C+1)'(a_s);

        d2_q[k]  <= d1_q[k];
        e1b_q[k] <= e1a_q[k];
        e2b_q[k] <= e2a_q[k];
        rb_q[k]  <= ra_q[k];
        p_q[k]   <= XW'(pm1) - XW'(pm2);
        q_q[k]   <= XW'(qm1) - XW'(qm2);

        det_t_q[k] <= det_m;
        un_t_q[k]  <= un_m;
        vn_t_q[k]  <= vn_m;
        tn_t_q[k]  <= tn_m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      md1_q <= maxd_i;
      md2_q <= md1_q;
      md3_q <= md2_q;
      md4_q <= md3_q;
      det_o <= DW'(det_t_q[0]) + DW'(det_t_q[1]) + DW'(det_t_q[2]);
      un_o  <= DW'(un_t_q[0]) + DW'(un_t_q[1]) + DW'(un_t_q[2]);
      vn_o  <= DW'(vn_t_q[0]) + DW'(vn_t_q[1]) + DW'(vn_t_q[2]);
      tn_o  <= DW'(tn_t_q[0]) + DW'(tn_t_q[1]) + DW'(tn_t_q[2]);
    end
  end

  assign valid_o = vld_q[3];
  assign maxd_o  = md4_q;

endmodule
`default_nettype wire

@@ rtl/rti_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rti_test: sign fold and hit test
// Three register stages: fold the determinant sign into all four sums and
// flag a nonzero determinant, check u/v bounds and the sign of t and form
// det*max_distance partial products, then the distance bound compare.
// ----------------------------------------------------------------------------
module rti_test
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            valid_i,
  input  logic signed [3*COORD_BITS+5:0]  det_i,
  input  logic signed [3*COORD_BITS+5:0]  un_i,
  input  logic signed [3*COORD_BITS+5:0]  vn_i,
  input  logic signed [3*COORD_BITS+5:0]  tn_i,
  input  logic [DIST_W-1:0]               maxd_i,
  output rti_flag_t                       flag_o,
  output logic [3*COORD_BITS+6:0]         det_o,
  output logic [3*COORD_BITS+6:0]         tn_o
);

  localparam int NW = 3 * COORD_BITS + 7;   // folded values, one sign bit spare
  localparam int ML = (NW + 1) / 2;         // low split of det for the multiply
  localparam int LW = ML + DIST_W;
  localparam int HW = NW - ML + DIST_W;
  localparam int BW = NW + DIST_W;

  rti_flag_t f1_q, f2_q, f3_q;

  logic signed [NW-1:0] det1_q, un1_q, vn1_q, tn1_q;
  logic [DIST_W-1:0]    md1_q;
  logic [NW-1:0]        det2_q, tn2_q, det3_q, tn3_q;
  logic [LW-1:0]        pl_q;
  logic [HW-1:0]        ph_q;

  logic                 neg;
  logic signed [NW-1:0] det_x, un_x, vn_x, tn_x;
  logic signed [NW:0]   uv_sum;
  logic                 ok_uvt;
  logic [BW-1:0]        bound;
  logic [BW-1:0]        scaled;

  assign neg   = det_i[NW-2];
  assign det_x = NW'(det_i);
  assign un_x  = NW'(un_i);
  assign vn_x  = NW'(vn_i);
  assign tn_x  = NW'(tn_i);

  assign uv_sum = (NW+1)'(un1_q) + (NW+1)'(vn1_q);
  assign ok_uvt = !un1_q[NW-1] && (un1_q <= det1_q) && !vn1_q[NW-1]
                  && (uv_sum <= (NW+1)'(det1_q)) && !tn1_q[NW-1];

  assign bound  = (BW'(ph_q) << ML) + BW'(pl_q);
  assign scaled = BW'(tn2_q) << FRAC_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
      f2_q <= '0;
      f3_q <= '0;
    end else if (adv_i) begin
      f1_q.valid <= valid_i;
      f1_q.hit   <= (det_i != '0);
      f2_q.valid <= f1_q.valid;
      f2_q.hit   <= f1_q.hit && ok_uvt;
      f3_q.valid <= f2_q.valid;
      f3_q.hit   <= f2_q.hit && (scaled <= bound);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // fold a negative determinant so that all tests compare against det > 0
      det1_q <= neg ? -det_x : det_x;
      un1_q  <= neg ? -un_x  : un_x;
      vn1_q  <= neg ? -vn_x  : vn_x;
      tn1_q  <= neg ? -tn_x  : tn_x;
      md1_q  <= maxd_i;

      det2_q <= det1_q;
      tn2_q  <= tn1_q;
      pl_q   <= LW'(det1_q[ML-1:0]) * LW'(md1_q);
      ph_q   <= HW'(det1_q[NW-1:ML]) * HW'(md1_q);

      det3_q <= det2_q;
      tn3_q  <= tn2_q;
    end
  end

  assign flag_o = f3_q;
  assign det_o  = det3_q;
  assign tn_o   = tn3_q;

endmodule
`default_nettype wire

@@ rtl/rti_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div: pipelined restoring divider for the distance
// One quotient bit per stage, DIST_W stages. Divides tn * 2^FRAC_W by det;
// the bound test upstream keeps the quotient below 2^DIST_W on a hit.
// ----------------------------------------------------------------------------
module rti_div
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  rti_flag_t                   flag_i,
  input  logic [3*COORD_BITS+6:0]     det_i,
  input  logic [3*COORD_BITS+6:0]     tn_i,
  output rti_flag_t                   flag_o,
  output logic [DIST_W-1:0]           quot_o
);

  localparam int NW = 3 * COORD_BITS + 7;
  localparam int NS = DIST_W;

  rti_flag_t         flag_q [NS];
  logic [NW-1:0]     rem_q  [NS];
  logic [NW-1:0]     den_q  [NS];
  logic [DIST_W-1:0] num_q  [NS];
  logic [DIST_W-1:0] quo_q  [NS];

  genvar k;
  for (k = 0; k < NS; k++) begin : g_stage
    rti_flag_t         f_s;
    logic [NW-1:0]     r_s, dn_s;
    logic [DIST_W-1:0] n_s, q_s;
    logic [NW:0]       trial;
    logic [NW+1:0]     diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign f_s  = flag_i;
      assign r_s  = NW'(tn_i[NW-1:FRAC_W]);
      assign dn_s = det_i;
      assign n_s  = {tn_i[FRAC_W-1:0], {(DIST_W-FRAC_W){1'b0}}};
      assign q_s  = '0;
    end else begin : g_next
      assign f_s  = flag_q[k-1];
      assign r_s  = rem_q[k-1];
      assign dn_s = den_q[k-1];
      assign n_s  = num_q[k-1];
      assign q_s  = quo_q[k-1];
    end

    assign trial = {r_s, n_s[DIST_W-1]};
    assign diff  = (NW+2)'(trial) - (NW+2)'(dn_s);
    assign ge    = !diff[NW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        flag_q[k] <= '0;
      end else if (adv_i) begin
        flag_q[k] <= f_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= ge ? diff[NW-1:0] : trial[NW-1:0];
        den_q[k] <= dn_s;
        num_q[k] <= {n_s[DIST_W-2:0], 1'b0};
        quo_q[k] <= {q_s[DIST_W-2:0], ge};
      end
    end
  end

  assign flag_o = flag_q[NS-1];
  assign quot_o = quo_q[NS-1];

endmodule
`default_nettype wire
